// ===== design/ostt_pkg.sv =====
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared types and constants of the one-shot timer table.
// ----------------------------------------------------------------------------
package ostt_pkg;

  localparam int unsigned TableDepthDef = 16;
  localparam int unsigned OwnerBitsDef  = 8;
  localparam int unsigned MaxResults    = 16;

  typedef enum logic [1:0] {
    OP_SET     = 2'd0,
    OP_TICK    = 2'd1,
    OP_PAUSE   = 2'd2,
    OP_UNPAUSE = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    KIND_SET     = 3'd0,
    KIND_EXPIRED = 3'd1,
    KIND_NONE    = 3'd2,
    KIND_FULL    = 3'd3,
    KIND_DONE    = 3'd4
  } kind_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [31:0] now;
    logic [31:0] duration;
    logic [7:0]  owner;
  } req_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] timer_id;
    logic [7:0]  owner_tag;
    logic        last;
  } rsp_t;

endpackage

// ===== design/ostt_if.sv =====
// ----------------------------------------------------------------------------
// ostt_if
// Valid/ready channel that carries one request or one response.
// ----------------------------------------------------------------------------
interface ostt_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/one_shot_timer_table.sv =====
// ----------------------------------------------------------------------------
// one_shot_timer_table
// A set is answered from the output register in the cycle after it is accepted. Tick,
// pause and unpause read each stored entry in turn and process it in ST_PROC, with
// ST_READ between entries, then give their last response from ST_END; an empty
// table goes straight to ST_END. Response stalls can hold these steps.
// One transaction is handled at a time; a response waits in an output register.
// Reset clears the entry count and the id counter; table contents stay unknown.
// ----------------------------------------------------------------------------
module one_shot_timer_table #(
  parameter int unsigned TABLE_DEPTH = ostt_pkg::TableDepthDef,
  parameter int unsigned OWNER_BITS  = ostt_pkg::OwnerBitsDef
) (
  input logic clk_i,
  input logic rst_ni,
  ostt_if.sink   req_i,
  ostt_if.source rsp_o
);
  import ostt_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [31:0]           fire;
    logic [31:0]           start;
    logic [31:0]           len;
    logic [31:0]           id;
    logic [OWNER_BITS-1:0] own;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_READ = 4'b0010,
    ST_PROC = 4'b0100,
    ST_END  = 4'b1000
  } state_e;

  entry_t mem [TABLE_DEPTH];
  entry_t rd_q;
  logic   we;
  logic [AW-1:0] wa, ra;
  entry_t wd;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
  end

  state_e        st_q, st_d;
  logic [CW-1:0] cnt_q, cnt_d, rp_q, rp_d, keep_q, keep_d;
  logic [4:0]    n_q, n_d;
  logic [31:0]   nid_q, nid_d;
  req_t          req_q, req_d;
  logic          ov_q, ov_d;
  rsp_t          out_q, out_d;
  logic [31:0]   hid_q, hid_d;
  logic [OWNER_BITS-1:0] hown_q, hown_d;

  logic [31:0] elapsed;
  logic        has_more, fired;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; rp_d = rp_q; keep_d = keep_q; n_d = n_q;
    nid_d = nid_q; req_d = req_q; ov_d = ov_q; out_d = out_q;
    hid_d = hid_q; hown_d = hown_q;
    we = 1'b0; wa = '0; wd = rd_q; ra = rp_q[AW-1:0];
    elapsed = req_q.now - rd_q.start;
    has_more = (rp_q + CW'(1)) < cnt_q;
    fired = (rd_q.fire <= req_q.now) && (n_q < 5'(MaxResults));
    req_i.ready = (st_q == ST_IDLE) && (!ov_q || rsp_o.ready);
    if (ov_q && rsp_o.ready) ov_d = 1'b0;
    case (st_q)
      ST_IDLE: begin
        if (req_i.valid && req_i.ready) begin
          req_d = req_i.data;
          rp_d = '0; keep_d = '0; n_d = '0;
          if (req_i.data.operation == OP_SET) begin
            ov_d = 1'b1;
            out_d.last = 1'b1;
            if (cnt_q >= CW'(TABLE_DEPTH)) begin
              out_d.kind = KIND_FULL; out_d.timer_id = '0; out_d.owner_tag = '0;
            end else begin
              we = 1'b1; wa = cnt_q[AW-1:0];
              wd.start = req_i.data.now;
              wd.len = req_i.data.duration;
              wd.fire = req_i.data.now + req_i.data.duration;
              wd.id = nid_q;
              wd.own = OWNER_BITS'(req_i.data.owner);
              cnt_d = cnt_q + CW'(1);
              nid_d = nid_q + 32'd1;
              out_d.kind = KIND_SET; out_d.timer_id = nid_q;
              out_d.owner_tag = 8'(OWNER_BITS'(req_i.data.owner));
            end
          end else if (cnt_q == '0) begin
            st_d = ST_END;
          end else begin
            ra = '0;
            st_d = ST_PROC;
          end
        end
      end
      ST_READ: begin
        st_d = ST_PROC;
      end
      ST_PROC: begin
        if (req_q.operation == OP_TICK && fired) begin
          if (n_q == '0 || !ov_d) begin
            if (n_q != '0) begin
              ov_d = 1'b1;
              out_d.kind = KIND_EXPIRED; out_d.timer_id = hid_q;
              out_d.owner_tag = 8'(hown_q); out_d.last = 1'b0;
            end
            hid_d = rd_q.id; hown_d = rd_q.own;
            n_d = n_q + 5'd1;
            if (has_more) begin
              rp_d = rp_q + CW'(1); ra = rp_d[AW-1:0]; st_d = ST_READ;
            end else begin
              cnt_d = keep_q; st_d = ST_END;
            end
          end
        end else begin
          we = 1'b1;
          if (req_q.operation == OP_TICK) begin
            wa = keep_q[AW-1:0]; keep_d = keep_q + CW'(1);
          end else begin
            wa = rp_q[AW-1:0];
            if (req_q.operation == OP_PAUSE) begin
              wd.len = (elapsed >= rd_q.len) ? 32'd0 : rd_q.len - elapsed;
            end else begin
              wd.start = req_q.now; wd.fire = req_q.now + rd_q.len;
            end
          end
          if (has_more) begin
            rp_d = rp_q + CW'(1); ra = rp_d[AW-1:0]; st_d = ST_READ;
          end else begin
            if (req_q.operation == OP_TICK) cnt_d = keep_d;
            st_d = ST_END;
          end
        end
      end
      ST_END: begin
        if (req_q.operation == OP_TICK && n_q != '0) begin
          if (!ov_d) begin
            ov_d = 1'b1; out_d.last = 1'b1;
            out_d.kind = KIND_EXPIRED;
            out_d.timer_id = hid_q; out_d.owner_tag = 8'(hown_q);
            st_d = ST_IDLE;
          end
        end else if (!ov_d) begin
          ov_d = 1'b1; out_d.last = 1'b1;
          out_d.kind = (req_q.operation == OP_TICK) ? KIND_NONE : KIND_DONE;
          out_d.timer_id = '0; out_d.owner_tag = '0;
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  assign rsp_o.valid = ov_q;
  assign rsp_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; cnt_q <= '0; nid_q <= '0; ov_q <= 1'b0;
      rp_q <= '0; keep_q <= '0; n_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d; nid_q <= nid_d; ov_q <= ov_d;
      rp_q <= rp_d; keep_q <= keep_d; n_q <= n_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q  <= req_d;
    out_q  <= out_d;
    hid_q  <= hid_d;
    hown_q <= hown_d;
  end

endmodule

// ===== tb/ostt_checker.sv =====
// ----------------------------------------------------------------------------
// ostt_checker
// Watches the request and response channels of the one-shot timer table,
// keeps its own copy of the timer table, predicts every response and
// compares each accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module ostt_checker
  import ostt_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  logic        req_ready_i,
  input  req_t        req_data_i,
  input  logic        rsp_valid_i,
  input  logic        rsp_ready_i,
  input  rsp_t        rsp_data_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct {
    logic [31:0] fire;
    logic [31:0] start;
    logic [31:0] length;
    logic [31:0] id;
    logic [7:0]  owner;
  } timer_t;

  timer_t      timers[$];
  logic [31:0] id_counter;
  rsp_t        expected_rsps[$];

  assign pending_o = expected_rsps.size();

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t: %s", $realtime, what);
    errors_o++;
  endtask

  function automatic rsp_t make_rsp(kind_e k, logic [31:0] id, logic [7:0] tag, logic lst);
    rsp_t r;
    r.kind      = k;
    r.timer_id  = id;
    r.owner_tag = tag;
    r.last      = lst;
    return r;
  endfunction

  task automatic apply_request(input req_t rq);
    timer_t kept[$];
    timer_t t;
    int     fired;
    logic [31:0] elapsed;
    fired = 0;
    case (op_e'(rq.operation))
      OP_SET: begin
        if (timers.size() >= DEPTH) begin
          expected_rsps.push_back(make_rsp(KIND_FULL, '0, '0, 1'b1));
        end else begin
          t.start  = rq.now;
          t.length = rq.duration;
          t.fire   = rq.now + rq.duration;
          t.id     = id_counter;
          t.owner  = rq.owner;
          timers.push_back(t);
          expected_rsps.push_back(make_rsp(KIND_SET, id_counter, rq.owner, 1'b1));
          id_counter++;
        end
      end
      OP_TICK: begin
        foreach (timers[i]) begin
          if (timers[i].fire <= rq.now && fired < MaxResults) begin
            expected_rsps.push_back(make_rsp(KIND_EXPIRED, timers[i].id,
                                             timers[i].owner, 1'b0));
            fired++;
          end else begin
            kept.push_back(timers[i]);
          end
        end
        timers = kept;
        if (fired == 0) begin
          expected_rsps.push_back(make_rsp(KIND_NONE, '0, '0, 1'b1));
        end else begin
          expected_rsps[expected_rsps.size()-1].last = 1'b1;
        end
      end
      OP_PAUSE: begin
        foreach (timers[i]) begin
          elapsed = rq.now - timers[i].start;
          timers[i].length = (elapsed >= timers[i].length) ? '0
                                                           : timers[i].length - elapsed;
        end
        expected_rsps.push_back(make_rsp(KIND_DONE, '0, '0, 1'b1));
      end
      default: begin
        foreach (timers[i]) begin
          timers[i].start = rq.now;
          timers[i].fire  = rq.now + timers[i].length;
        end
        expected_rsps.push_back(make_rsp(KIND_DONE, '0, '0, 1'b1));
      end
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t want;
    if (!rst_ni) begin
      timers.delete();
      expected_rsps.delete();
      id_counter = '0;
      errors_o   = 0;
    end else begin
      if (rsp_valid_i && rsp_ready_i) begin
        if (expected_rsps.size() == 0) begin
          report_mismatch("response with no prediction waiting");
        end else begin
          want = expected_rsps.pop_front();
          if (rsp_data_i.kind !== want.kind)
            report_mismatch($sformatf("kind %0d, predicted %0d", rsp_data_i.kind, want.kind));
          if (rsp_data_i.timer_id !== want.timer_id)
            report_mismatch($sformatf("timer_id %0d, predicted %0d",
                                      rsp_data_i.timer_id, want.timer_id));
          if (rsp_data_i.owner_tag !== want.owner_tag)
            report_mismatch($sformatf("owner_tag %0d, predicted %0d",
                                      rsp_data_i.owner_tag, want.owner_tag));
          if (rsp_data_i.last !== want.last)
            report_mismatch($sformatf("last %0d, predicted %0d",
                                      rsp_data_i.last, want.last));
        end
      end
      if (req_valid_i && req_ready_i) apply_request(req_data_i);
    end
  end

endmodule

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives set, tick, pause and unpause transactions into the one-shot timer
// table with random gaps and response stalls; a checker module predicts and
// compares every response, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import ostt_pkg::*;

  localparam int unsigned Depth      = 16;
  localparam int          IdleLimit  = 5000;

  logic clk_i;
  logic rst_ni;
  int   errors;
  int   pending;
  int   idle_cycles;
  int   idle_pct;

  ostt_if #(.payload_t(req_t)) req_if ();
  ostt_if #(.payload_t(rsp_t)) rsp_if ();

  one_shot_timer_table #(.TABLE_DEPTH(Depth), .OWNER_BITS(8)) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if.sink),
    .rsp_o (rsp_if.source)
  );

  ostt_checker #(.DEPTH(Depth)) u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_if.valid),
    .req_ready_i(req_if.ready),
    .req_data_i (req_if.data),
    .rsp_valid_i(rsp_if.valid),
    .rsp_ready_i(rsp_if.ready),
    .rsp_data_i (rsp_if.data),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      idle_cycles <= 0;
    end else if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic send_request(input op_e op, input logic [31:0] now,
                              input logic [31:0] dur, input logic [7:0] own);
    req_t rq;
    while ($urandom_range(99) < idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    rq.operation = op;
    rq.now       = now;
    rq.duration  = dur;
    rq.owner     = own;
    req_if.valid <= 1'b1;
    req_if.data  <= rq;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
  endtask

  task automatic random_sequence(inout logic [31:0] clock_ms, inout int sent);
    int n;
    n = $urandom_range(1, 10);
    for (int k = 0; k < n; k++) begin
      clock_ms += $urandom_range(0, 60);
      send_request(OP_SET, clock_ms, $urandom_range(0, 300), 8'($urandom));
    end
    for (int k = 0; k < 4; k++) begin
      clock_ms += $urandom_range(0, 200);
      case ($urandom_range(5))
        0: send_request(OP_PAUSE, clock_ms, $urandom, 8'($urandom));
        1: send_request(OP_UNPAUSE, clock_ms, $urandom, 8'($urandom));
        default: send_request(OP_TICK, clock_ms, $urandom, 8'($urandom));
      endcase
    end
    sent += n + 4;
  endtask

  initial begin
    logic [31:0] clock_ms;
    int          sent;
    req_if.valid = 1'b0;
    req_if.data  = '0;
    idle_pct     = 17;
    @(posedge rst_ni);
    @(posedge clk_i);

    send_request(OP_TICK, 32'd0, 32'd0, 8'd0);
    send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_SET, 32'd0, 32'd0, 8'h00);
    send_request(OP_SET, 32'd100, 32'hFFFF_FFF0, 8'hA5);
    send_request(OP_SET, 32'hFFFF_FF00, 32'd10, 8'h5A);
    for (int k = 0; k < 13; k++) send_request(OP_SET, 32'd5, 32'(k), 8'(k));
    send_request(OP_PAUSE, 32'd7, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_UNPAUSE, 32'd1000, 32'd0, 8'd0);
    send_request(OP_TICK, 32'd1005, 32'hFFFF_FFFF, 8'hFF);
    send_request(OP_TICK, 32'hFFFF_FFFF, 32'd0, 8'd0);
    send_request(OP_TICK, 32'hFFFF_FFFF, 32'd0, 8'd0);
    sent = 23;
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);

    idle_pct = 0;
    clock_ms = 32'd0;
    while (sent < 80) begin
      random_sequence(clock_ms, sent);
    end
    idle_pct = 17;
    while (sent < 230) begin
      if ($urandom_range(9) == 0) begin
        send_request(op_e'($urandom_range(3)), $urandom, $urandom, 8'($urandom));
        sent++;
      end else begin
        random_sequence(clock_ms, sent);
      end
    end
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
